@@ sv/trlp_pkg.sv @@
// Shared types and constants for the text record line parser.
package trlp_pkg;

  // Result kinds as they appear on the kind port.
  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_TEXT   = 2'd1,
    KIND_END    = 2'd2,
    KIND_REJECT = 2'd3
  } kind_t;

  // Field the parser is currently gathering.
  typedef enum logic [3:0] {
    PH_FIRST  = 4'b0001,
    PH_SECOND = 4'b0010,
    PH_TIME   = 4'b0100,
    PH_TEXT   = 4'b1000
  } phase_t;

  // Character codes.
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [7:0] CHAR_COLON = 8'd58;

  // Numeric limits of the fields.
  localparam logic [19:0] U_LIMIT     = 20'd65535;
  localparam logic [35:0] S_POS_LIMIT = 36'd2147483647;
  localparam logic [35:0] S_NEG_LIMIT = 36'd2147483648;
  localparam logic [6:0]  HOUR_MAX    = 7'd23;
  localparam logic [6:0]  MINSEC_MAX  = 7'd59;
  localparam logic [3:0]  TIME_LEN    = 4'd8;
  localparam logic [3:0]  COUNT_MAX   = 4'd15;

  // Depth of the request queue between parser and output stage.
  localparam int CMD_DEPTH = 4;
  localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
  localparam logic [CMD_CNT_W-1:0] CMD_FULL = CMD_CNT_W'(CMD_DEPTH);

  // One request from the parser: an optional text byte, then an optional
  // main result (header, accepted end or reject).
  typedef struct packed {
    logic        pre_text;
    logic [7:0]  text_char;
    logic        has_main;
    kind_t       main_kind;
    logic [31:0] message_index;
    logic [15:0] first_number;
    logic [31:0] second_number;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [31:0] text_length;
  } cmd_t;

endpackage

@@ sv/trlp_front.sv @@
// Line parser: takes input bytes, tracks the fields and issues requests.
module trlp_front import trlp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic       mode,
  input  logic [7:0] data_byte,
  output logic       cmd_valid,
  output cmd_t       cmd
);

  phase_t      phase, phase_next;
  logic [3:0]  char_count, char_count_next;
  logic [15:0] uacc, uacc_next;
  logic [31:0] smag, smag_next;
  logic        minus_seen, minus_seen_next;
  logic [6:0]  tp [3];
  logic [6:0]  tp_next [3];
  logic        line_bad, line_bad_next;
  logic        line_nonempty, line_nonempty_next;
  logic [7:0]  held_char, held_char_next;
  logic        held_valid, held_valid_next;
  logic [31:0] text_counter, text_counter_next;
  logic [31:0] accepted_count, accepted_count_next;

  // Digit decode and the candidate accumulator values.
  logic        is_digit;
  logic [3:0]  digit;
  logic [19:0] u_cand;
  logic [35:0] s_cand;
  logic [35:0] s_limit;
  logic [1:0]  tp_sel;
  logic [10:0] tp_cand;
  logic        time_bad;
  logic        pre;

  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  assign digit    = data_byte[3:0];
  assign u_cand   = {4'd0, uacc} * 20'd10 + {16'd0, digit};
  assign s_cand   = {4'd0, smag} * 36'd10 + {32'd0, digit};
  assign s_limit  = minus_seen ? S_NEG_LIMIT : S_POS_LIMIT;
  assign time_bad = (char_count != TIME_LEN) || (tp[0] > HOUR_MAX) ||
                    (tp[1] > MINSEC_MAX) || (tp[2] > MINSEC_MAX);

  // Which time part a digit position belongs to.
  always_comb begin
    if (char_count < 4'd3) begin
      tp_sel = 2'd0;
    end else if (char_count < 4'd6) begin
      tp_sel = 2'd1;
    end else begin
      tp_sel = 2'd2;
    end
  end
  assign tp_cand = {4'd0, tp[tp_sel]} * 11'd10 + {7'd0, digit};

  // Next-state and request logic for one accepted byte.
  always_comb begin
    pre                 = 1'b0;
    phase_next          = phase;
    char_count_next     = char_count;
    uacc_next           = uacc;
    smag_next           = smag;
    minus_seen_next     = minus_seen;
    tp_next             = tp;
    line_bad_next       = line_bad;
    line_nonempty_next  = line_nonempty;
    held_char_next      = held_char;
    held_valid_next     = held_valid;
    text_counter_next   = text_counter;
    accepted_count_next = accepted_count;
    cmd_valid           = 1'b0;
    cmd                 = '0;

    if (accept) begin
      if (mode || (data_byte == CHAR_LF)) begin
        // Line end: empty lines and a lone CR give nothing.
        if (!line_nonempty ||
            ((phase == PH_FIRST) && (char_count == 4'd1) && (held_char == CHAR_CR))) begin
          cmd_valid = 1'b0;
        end else if ((phase != PH_TEXT) || line_bad) begin
          cmd_valid      = 1'b1;
          cmd.has_main   = 1'b1;
          cmd.main_kind  = KIND_REJECT;
        end else begin
          // Flush the held byte unless it is the trailing CR.
          pre               = held_valid && (held_char != CHAR_CR);
          cmd_valid         = 1'b1;
          cmd.pre_text      = pre;
          cmd.text_char     = pre ? held_char : 8'd0;
          cmd.has_main      = 1'b1;
          cmd.main_kind     = KIND_END;
          cmd.message_index = accepted_count;
          cmd.text_length   = (pre && (text_counter != '1)) ? text_counter + 32'd1
                                                            : text_counter;
          accepted_count_next = accepted_count + 32'd1;
        end
        phase_next         = PH_FIRST;
        char_count_next    = 4'd0;
        uacc_next          = 16'd0;
        smag_next          = 32'd0;
        minus_seen_next    = 1'b0;
        tp_next[0]         = 7'd0;
        tp_next[1]         = 7'd0;
        tp_next[2]         = 7'd0;
        line_bad_next      = 1'b0;
        line_nonempty_next = 1'b0;
        held_char_next     = 8'd0;
        held_valid_next    = 1'b0;
        text_counter_next  = 32'd0;
      end else begin
        line_nonempty_next = 1'b1;
        if (phase == PH_TEXT) begin
          // Text: emit the previously held byte and hold this one.
          if (!line_bad) begin
            if (held_valid) begin
              cmd_valid     = 1'b1;
              cmd.pre_text  = 1'b1;
              cmd.text_char = held_char;
              if (text_counter != '1) begin
                text_counter_next = text_counter + 32'd1;
              end
            end
            held_char_next  = data_byte;
            held_valid_next = 1'b1;
          end
        end else begin
          held_char_next = data_byte;
          if (data_byte == CHAR_SPACE) begin
            // Field separator: check the finished field and advance.
            char_count_next = 4'd0;
            if (phase == PH_FIRST) begin
              if (char_count == 4'd0) begin
                line_bad_next = 1'b1;
              end
              phase_next = PH_SECOND;
            end else if (phase == PH_SECOND) begin
              if (char_count == {3'd0, minus_seen}) begin
                line_bad_next = 1'b1;
              end
              phase_next = PH_TIME;
            end else begin
              if (time_bad) begin
                line_bad_next = 1'b1;
              end
              if (!line_bad && !time_bad) begin
                cmd_valid         = 1'b1;
                cmd.has_main      = 1'b1;
                cmd.main_kind     = KIND_HEADER;
                cmd.message_index = accepted_count;
                cmd.first_number  = uacc;
                cmd.second_number = minus_seen ? (32'd0 - smag) : smag;
                cmd.hours         = tp[0][4:0];
                cmd.minutes       = tp[1][5:0];
                cmd.seconds       = tp[2][5:0];
              end
              phase_next = PH_TEXT;
            end
          end else begin
            // Field character.
            if (phase == PH_FIRST) begin
              if (!is_digit) begin
                line_bad_next = 1'b1;
              end else if (!line_bad) begin
                if (u_cand > U_LIMIT) begin
                  line_bad_next = 1'b1;
                end else begin
                  uacc_next = u_cand[15:0];
                end
              end
            end else if (phase == PH_SECOND) begin
              if ((char_count == 4'd0) && (data_byte == CHAR_MINUS)) begin
                minus_seen_next = 1'b1;
              end else if (!is_digit) begin
                line_bad_next = 1'b1;
              end else if (!line_bad) begin
                if (s_cand > s_limit) begin
                  line_bad_next = 1'b1;
                end else begin
                  smag_next = s_cand[31:0];
                end
              end
            end else begin
              if (char_count >= TIME_LEN) begin
                line_bad_next = 1'b1;
              end else if ((char_count == 4'd2) || (char_count == 4'd5)) begin
                if (data_byte != CHAR_COLON) begin
                  line_bad_next = 1'b1;
                end
              end else if (!is_digit) begin
                line_bad_next = 1'b1;
              end else begin
                tp_next[tp_sel] = tp_cand[6:0];
              end
            end
            if (char_count < COUNT_MAX) begin
              char_count_next = char_count + 4'd1;
            end
          end
        end
      end
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_FIRST;
      char_count     <= 4'd0;
      uacc           <= 16'd0;
      smag           <= 32'd0;
      minus_seen     <= 1'b0;
      tp[0]          <= 7'd0;
      tp[1]          <= 7'd0;
      tp[2]          <= 7'd0;
      line_bad       <= 1'b0;
      line_nonempty  <= 1'b0;
      held_char      <= 8'd0;
      held_valid     <= 1'b0;
      text_counter   <= 32'd0;
      accepted_count <= 32'd0;
    end else begin
      phase          <= phase_next;
      char_count     <= char_count_next;
      uacc           <= uacc_next;
      smag           <= smag_next;
      minus_seen     <= minus_seen_next;
      tp             <= tp_next;
      line_bad       <= line_bad_next;
      line_nonempty  <= line_nonempty_next;
      held_char      <= held_char_next;
      held_valid     <= held_valid_next;
      text_counter   <= text_counter_next;
      accepted_count <= accepted_count_next;
    end
  end

endmodule

@@ sv/trlp_cmd_queue.sv @@
// Short request queue between the parser and the output stage.
module trlp_cmd_queue import trlp_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  cmd_t in_cmd,
  output logic full,
  output logic out_valid,
  output cmd_t out_cmd,
  input  logic out_take
);

  cmd_t                 slots [CMD_DEPTH];
  logic [CMD_PTR_W-1:0] wr_ptr;
  logic [CMD_PTR_W-1:0] rd_ptr;
  logic [CMD_CNT_W-1:0] count;
  logic                 do_write;
  logic                 do_read;

  assign full      = (count == CMD_FULL);
  assign out_valid = (count != '0);
  assign out_cmd   = slots[rd_ptr];
  assign do_write  = in_valid && !full;
  assign do_read   = out_take && out_valid;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_write) begin
        wr_ptr <= wr_ptr + CMD_PTR_W'(1);
      end
      if (do_read) begin
        rd_ptr <= rd_ptr + CMD_PTR_W'(1);
      end
      if (do_write && !do_read) begin
        count <= count + CMD_CNT_W'(1);
      end else if (!do_write && do_read) begin
        count <= count - CMD_CNT_W'(1);
      end
    end
  end

  // Request storage.
  always_ff @(posedge clk) begin
    if (do_write) begin
      slots[wr_ptr] <= in_cmd;
    end
  end

endmodule

@@ sv/trlp_back.sv @@
// Output stage: expands each request into one or two results.
module trlp_back import trlp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  cmd_t               q_cmd,
  output logic               q_take,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic [31:0]        message_index,
  output logic [15:0]        first_number,
  output logic signed [31:0] second_number,
  output logic [4:0]         hours,
  output logic [5:0]         minutes,
  output logic [5:0]         seconds,
  output logic [7:0]         text_char,
  output logic [31:0]        text_length,
  output logic               last_of_run
);

  logic        out_valid;
  logic        text_sent;
  logic        load;
  logic        emit_text;
  kind_t       kind_r;
  logic [31:0] index_r;
  logic [15:0] first_r;
  logic [31:0] second_r;
  logic [4:0]  hours_r;
  logic [5:0]  minutes_r;
  logic [5:0]  seconds_r;
  logic [7:0]  char_r;
  logic [31:0] length_r;
  logic        last_r;

  // The output register loads whenever it is empty or being drained.
  assign load      = !out_valid || pop;
  assign emit_text = q_cmd.pre_text && !text_sent;
  assign q_take    = load && q_valid && !(emit_text && q_cmd.has_main);
  assign empty     = !out_valid;

  // Control: output valid and the split-request marker.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      text_sent <= 1'b0;
    end else if (load) begin
      out_valid <= q_valid;
      if (q_valid) begin
        text_sent <= emit_text && q_cmd.has_main;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (load && q_valid) begin
      if (emit_text) begin
        kind_r    <= KIND_TEXT;
        index_r   <= 32'd0;
        first_r   <= 16'd0;
        second_r  <= 32'd0;
        hours_r   <= 5'd0;
        minutes_r <= 6'd0;
        seconds_r <= 6'd0;
        char_r    <= q_cmd.text_char;
        length_r  <= 32'd0;
        last_r    <= !q_cmd.has_main;
      end else begin
        kind_r    <= q_cmd.main_kind;
        index_r   <= q_cmd.message_index;
        first_r   <= q_cmd.first_number;
        second_r  <= q_cmd.second_number;
        hours_r   <= q_cmd.hours;
        minutes_r <= q_cmd.minutes;
        seconds_r <= q_cmd.seconds;
        char_r    <= 8'd0;
        length_r  <= q_cmd.text_length;
        last_r    <= 1'b1;
      end
    end
  end

  assign kind          = kind_r;
  assign message_index = index_r;
  assign first_number  = first_r;
  assign second_number = second_r;
  assign hours         = hours_r;
  assign minutes       = minutes_r;
  assign seconds       = seconds_r;
  assign text_char     = char_r;
  assign text_length   = length_r;
  assign last_of_run   = last_r;

endmodule

@@ sv/text_record_line_parser_top.sv @@
// Top level of the text record line parser.
// The block takes one byte per cycle while full is low, and it does not
// wait for earlier results to be popped as long as the four-entry request
// queue between the parser and the output stage has room. A byte yields
// zero, one or two results; results leave the output register at one per
// cycle while pop is high, so a byte that closes an accepted line with a
// pending text byte gives its text result before its end result. The
// first result of a byte passes through the request queue and then the
// output register: the request is written to the queue at the accepting
// edge and loaded into the output register when it is empty or popped.
// Lines end on byte 10 or on mode high; trailing CR is dropped from text.
module text_record_line_parser_top import trlp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic               mode,
  input  logic [7:0]         data_byte,
  output logic               empty,
  input  logic               pop,
  output logic [1:0]         kind,
  output logic [31:0]        message_index,
  output logic [15:0]        first_number,
  output logic signed [31:0] second_number,
  output logic [4:0]         hours,
  output logic [5:0]         minutes,
  output logic [5:0]         seconds,
  output logic [7:0]         text_char,
  output logic [31:0]        text_length,
  output logic               last_of_run
);

  logic accept;
  logic cmd_valid;
  cmd_t cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_take;

  assign accept = push && !full;

  // Parser.
  trlp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .mode      (mode),
    .data_byte (data_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  // Request queue.
  trlp_cmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd_valid),
    .in_cmd    (cmd),
    .full      (full),
    .out_valid (q_valid),
    .out_cmd   (q_cmd),
    .out_take  (q_take)
  );

  // Output stage.
  trlp_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_take        (q_take),
    .empty         (empty),
    .pop           (pop),
    .kind          (kind),
    .message_index (message_index),
    .first_number  (first_number),
    .second_number (second_number),
    .hours         (hours),
    .minutes       (minutes),
    .seconds       (seconds),
    .text_char     (text_char),
    .text_length   (text_length),
    .last_of_run   (last_of_run)
  );

endmodule

@@ test/text_record_line_parser_top_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the text record line parser top level.
module text_record_line_parser_top_tb;
  import trlp_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 500000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned RANDOM_ITEMS = 400;

  typedef logic [7:0] byte_q_t[$];

  // One result as the block should present it.
  typedef struct {
    kind_t       kind;
    logic [31:0] index;
    logic [15:0] first_num;
    logic [31:0] second_num;
    logic [4:0]  hh;
    logic [5:0]  mm;
    logic [5:0]  ss;
    logic [7:0]  ch;
    logic [31:0] len;
    logic        last;
  } parse_result_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               push = 1'b0;
  logic               full;
  logic               mode = 1'b0;
  logic [7:0]         data_byte = 8'd0;
  logic               empty;
  logic               pop = 1'b0;
  logic [1:0]         kind;
  logic [31:0]        message_index;
  logic [15:0]        first_number;
  logic signed [31:0] second_number;
  logic [4:0]         hours;
  logic [5:0]         minutes;
  logic [5:0]         seconds;
  logic [7:0]         text_char;
  logic [31:0]        text_length;
  logic               last_of_run;

  text_record_line_parser_top DUT (.*);

  // Line parser state as predicted from the accepted requests.
  phase_t      ph;
  logic [3:0]  fld_cnt;
  logic [16:0] u_acc;
  logic [31:0] s_mag;
  logic        neg;
  logic [6:0]  tpart [3];
  logic        bad;
  logic        nonempty;
  logic [7:0]  held;
  logic        held_v;
  logic [31:0] text_cnt;
  logic [31:0] msg_cnt;

  parse_result_t step_results[$];
  parse_result_t expected_results[$];

  int unsigned error_count  = 0;
  int unsigned result_count = 0;
  int unsigned sent_count   = 0;
  int unsigned cycle_count  = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned stall_left   = 0;
  logic        calm         = 1'b0;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Guard against a hung handshake.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("text_record_line_parser_top_tb: done, errors");
    $finish;
  end

  // Print one failure line and count it.
  task automatic report_error(input string msg);
    $display("ERROR at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_error($sformatf("result %0d, %s: got 0x%0h, expected 0x%0h",
                             result_count, name, got, want));
  endtask

  // Clear the per-line state; the message count survives.
  function automatic void line_clear();
    ph = PH_FIRST;
    fld_cnt = '0;
    u_acc = '0;
    s_mag = '0;
    neg = 1'b0;
    foreach (tpart[i]) tpart[i] = '0;
    bad = 1'b0;
    nonempty = 1'b0;
    held = '0;
    held_v = 1'b0;
    text_cnt = '0;
  endfunction

  function automatic void queue_result(input kind_t k, input logic [31:0] idx,
                                       input logic [15:0] a, input logic [31:0] b,
                                       input logic [4:0] h, input logic [5:0] m,
                                       input logic [5:0] s, input logic [7:0] c,
                                       input logic [31:0] n);
    parse_result_t r;
    r = '{k, idx, a, b, h, m, s, c, n, 1'b0};
    step_results = {step_results, r};
  endfunction

  // A text byte result; the length counter saturates.
  function automatic void queue_text(input logic [7:0] c);
    queue_result(KIND_TEXT, '0, '0, '0, '0, '0, '0, c, '0);
    if (text_cnt != 32'hFFFF_FFFF) text_cnt++;
  endfunction

  // Work out the results of one accepted request and queue them.
  function automatic void predict_byte(input logic m, input logic [7:0] b);
    logic        digit;
    logic [3:0]  d;
    logic [35:0] t;
    int          k;
    step_results.delete();
    digit = (b >= CHAR_ZERO) && (b <= CHAR_NINE);
    d = 4'(b - CHAR_ZERO);
    if (m || b == CHAR_LF) begin
      // Line end: nothing for an empty line or a lone CR.
      if (!nonempty || (ph == PH_FIRST && fld_cnt == 4'd1 && held == CHAR_CR)) begin
      end else if (ph != PH_TEXT || bad) begin
        queue_result(KIND_REJECT, '0, '0, '0, '0, '0, '0, '0, '0);
      end else begin
        if (held_v && held != CHAR_CR) queue_text(held);
        queue_result(KIND_END, msg_cnt, '0, '0, '0, '0, '0, '0, text_cnt);
        msg_cnt++;
      end
      line_clear();
    end else begin
      nonempty = 1'b1;
      if (ph == PH_TEXT) begin
        // Text bytes go out one behind; a bad line swallows them.
        if (!bad) begin
          if (held_v) queue_text(held);
          held = b;
          held_v = 1'b1;
        end
      end else begin
        held = b;
        if (b == CHAR_SPACE) begin
          case (ph)
            PH_FIRST: if (fld_cnt == 0) bad = 1'b1;
            PH_SECOND: if (fld_cnt == (neg ? 4'd1 : 4'd0)) bad = 1'b1;
            default: begin
              if (fld_cnt != TIME_LEN || tpart[0] > HOUR_MAX || tpart[1] > MINSEC_MAX ||
                  tpart[2] > MINSEC_MAX)
                bad = 1'b1;
              if (!bad)
                queue_result(KIND_HEADER, msg_cnt, u_acc[15:0],
                             neg ? (32'd0 - s_mag) : s_mag,
                             tpart[0][4:0], tpart[1][5:0], tpart[2][5:0], '0, '0);
            end
          endcase
          ph = ph.next();
          fld_cnt = '0;
        end else begin
          case (ph)
            PH_FIRST: begin
              if (!digit) begin
                bad = 1'b1;
              end else if (!bad) begin
                t = 36'(u_acc) * 36'd10 + 36'(d);
                if (t > 36'(U_LIMIT)) bad = 1'b1;
                else u_acc = t[16:0];
              end
            end
            PH_SECOND: begin
              if (fld_cnt == 0 && b == CHAR_MINUS) begin
                neg = 1'b1;
              end else if (!digit) begin
                bad = 1'b1;
              end else if (!bad) begin
                t = 36'(s_mag) * 36'd10 + 36'(d);
                if (t > (neg ? S_NEG_LIMIT : S_POS_LIMIT)) bad = 1'b1;
                else s_mag = t[31:0];
              end
            end
            default: begin
              // Time field: colons at positions 2 and 5, digits elsewhere.
              if (fld_cnt >= TIME_LEN) begin
                bad = 1'b1;
              end else if (fld_cnt == 4'd2 || fld_cnt == 4'd5) begin
                if (b != CHAR_COLON) bad = 1'b1;
              end else if (!digit) begin
                bad = 1'b1;
              end else begin
                k = int'(fld_cnt) / 3;
                tpart[k] = tpart[k] * 7'd10 + 7'(d);
              end
            end
          endcase
          if (fld_cnt != COUNT_MAX) fld_cnt++;
        end
      end
    end
    if (step_results.size() > 0) step_results[$].last = 1'b1;
    expected_results = {expected_results, step_results};
  endfunction

  // Result side: random stall bursts, none once the run is calm.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
      pop <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      pop <= 1'b1;
    end
  end

  // Compare every popped result with the oldest expectation.
  always @(posedge clk) begin : result_check
    parse_result_t want;
    if (!rst && pop && !empty) begin
      if (expected_results.size() == 0) begin
        report_error($sformatf("result of kind %0d with nothing expected", kind));
      end else begin
        want = expected_results.pop_front();
        check_field("kind", kind, want.kind);
        check_field("message_index", message_index, want.index);
        check_field("first_number", first_number, want.first_num);
        check_field("second_number", second_number, want.second_num);
        check_field("hours", hours, want.hh);
        check_field("minutes", minutes, want.mm);
        check_field("seconds", seconds, want.ss);
        check_field("text_char", text_char, want.ch);
        check_field("text_length", text_length, want.len);
        check_field("last_of_run", last_of_run, want.last);
      end
      result_count++;
    end
  end

  // Send one request, after an optional idle burst, and predict it once taken.
  task automatic send_request(input logic m, input logic [7:0] b);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    push <= 1'b1;
    mode <= m;
    data_byte <= b;
    do @(posedge clk); while (full);
    predict_byte(m, b);
    sent_count++;
  endtask

  task automatic send_bytes(input byte_q_t q);
    foreach (q[i]) send_request(1'b0, q[i]);
  endtask

  // End of input; the data byte is don't-care and is randomized.
  task automatic send_eoi();
    send_request(1'b1, 8'($urandom));
  endtask

  function automatic byte_q_t to_bytes(input string s);
    byte_q_t q;
    int      i;
    for (i = 0; i < s.len(); i++) q = {q, 8'(s[i])};
    return q;
  endfunction

  task automatic send_text(input string s);
    send_bytes(to_bytes(s));
  endtask

  // Stop sending until every expected result has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  function automatic void pick_idling();
    int unsigned pick [4] = '{0, 0, 8, 40};
    gap_pct = pick[$urandom_range(0, 3)];
    stall_pct = pick[$urandom_range(0, 3)];
  endfunction

  // A record that is mostly well formed, with random fields and text.
  function automatic byte_q_t build_record();
    byte_q_t         q;
    string           s;
    longint unsigned mag;
    int unsigned     u, hh, mm, ss, len, i;
    logic [7:0]      b;
    case ($urandom_range(0, 9))
      0: u = 0;
      1: u = 65535;
      2: u = $urandom_range(65536, 70000);
      3: u = $urandom_range(0, 9);
      default: u = $urandom_range(0, 65535);
    endcase
    s = $sformatf("%0d ", u);
    if ($urandom_range(0, 7) == 0) s = {"00", s};
    if ($urandom_range(0, 1) == 1) s = {s, "-"};
    case ($urandom_range(0, 9))
      0: mag = 0;
      1: mag = 64'd2147483647;
      2: mag = 64'd2147483648;
      3: mag = 64'd2147483649 + $urandom_range(0, 1000);
      4: mag = $urandom_range(0, 99);
      default: mag = $urandom_range(0, 32'h7FFF_FFFF);
    endcase
    hh = ($urandom_range(0, 29) == 0) ? $urandom_range(24, 99) : $urandom_range(0, 23);
    mm = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    ss = ($urandom_range(0, 29) == 0) ? $urandom_range(60, 99) : $urandom_range(0, 59);
    s = {s, $sformatf("%0d %02d:%02d:%02d ", mag, hh, mm, ss)};
    q = to_bytes(s);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    for (i = 0; i < len; i++) begin
      b = 8'($urandom_range(0, 255));
      if (b == CHAR_LF) b = CHAR_CR;
      q = {q, b};
    end
    if ($urandom_range(0, 2) == 0) q = {q, CHAR_CR};
    return q;
  endfunction

  // Well-formed lines at the field extremes, and the handling of CR.
  task automatic test_accepted_lines();
    gap_pct = 20;
    stall_pct = 20;
    send_text("0 0 00:00:00 \n");
    send_text("65535 -2147483648 23:59:59 hello\015\n");
    send_text("00042 2147483647 09:05:07 a b\015c  \n");
    send_text("7 -0 12:34:56 \015\n");
    send_text("1 2 03:04:05 xyz");
    send_eoi();
    send_text("3 4 05:06:07 q\015");
    send_eoi();
  endtask

  // Each way a line can be rejected, plus lines that give nothing.
  task automatic test_rejected_lines();
    send_text(" 5 00:00:00 x\n");
    send_text("5 - 00:00:00 x\n");
    send_text("1  2 00:00:00 x\n");
    send_text("5 7 1:00:00 x\n");
    send_text("5 7 00:00:000 x\n");
    send_text("5 7 00:00:00:00:00:00:00 x\n");
    send_text("65536 0 00:00:00 x\n");
    send_text("1 2147483648 00:00:00 x\n");
    send_text("1 -2147483649 00:00:00 x\n");
    send_text("1 2 24:00:00 x\n");
    send_text("1 2 00:60:00 x\n");
    send_text("1 2 00:00:60 x\n");
    send_text("1a 2 00:00:00 x\n");
    send_text("1 2-3 00:00:00 x\n");
    send_text("1 2 00.00:00 x\n");
    send_text("1 2 0a:00:00 x\n");
    send_text("x 2 00:00:00 text of a bad line\n");
    send_text("1 2 00:00:00\n");
    send_text("12\n");
    send_text("1 2");
    send_eoi();
    send_eoi();
    send_text("\n");
    send_text("\015\n");
    send_text("\015\015\n");
  endtask

  // Bulk random lines: mostly records, some corrupted, cut short or noise.
  task automatic test_random_records();
    byte_q_t     line;
    int unsigned start, r, i, n;
    logic        paused;
    start = sent_count;
    paused = 1'b0;
    pick_idling();
    while (sent_count - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 7) == 0) pick_idling();
      r = $urandom_range(0, 99);
      line.delete();
      if (r < 3) begin
        line.delete();
      end else if (r < 5) begin
        line = {line, CHAR_CR};
      end else if (r < 8) begin
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) line = {line, 8'($urandom_range(0, 255))};
      end else begin
        line = build_record();
        if (r < 16) begin
          line[$urandom_range(0, line.size() - 1)] = 8'($urandom_range(0, 255));
        end else if (r < 21) begin
          n = $urandom_range(1, line.size() - 1);
          while (line.size() > n) void'(line.pop_back());
        end
      end
      send_bytes(line);
      if ($urandom_range(0, 9) == 0) send_eoi();
      else send_request(1'b0, CHAR_LF);
      // Halfway through, let the result side run dry once.
      if (!paused && sent_count - start > RANDOM_ITEMS / 2) begin
        wait_drained();
        paused = 1'b1;
      end
    end
  endtask

  // Back-to-back records with no idling on either side.
  task automatic test_steady_stream();
    int unsigned i;
    calm = 1'b1;
    for (i = 0; i < 12; i++) begin
      send_bytes(build_record());
      send_request(1'b0, CHAR_LF);
    end
  endtask

  initial begin
    line_clear();
    msg_cnt = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_accepted_lines();
    wait_drained();
    test_rejected_lines();
    wait_drained();
    test_random_records();
    wait_drained();
    test_steady_stream();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("text_record_line_parser_top_tb: done, clean");
    end else begin
      $display("text_record_line_parser_top_tb: done, errors");
    end
    $finish;
  end

endmodule
